@@ rtl/oro_pkg.sv @@
// oro_pkg: shared constants, types and small tables for the oriented
// rectangle overlap test; no dependencies, used by every file in rtl/
`timescale 1ns / 1ps

package oro_pkg;

  // angle and trig formats
  localparam int ANGLE_BITS     = 16;
  localparam int TRIG_FRAC_BITS = 15;
  localparam int ADDR_W         = ANGLE_BITS - 1;
  localparam int QUARTER        = 1 << (ANGLE_BITS - 2);
  localparam int SIN_W          = TRIG_FRAC_BITS + 1;
  localparam int TRIG_W         = TRIG_FRAC_BITS + 2;

  // geometry widths
  localparam int COORD_W      = 24;
  localparam int SIZE_W       = 23;
  localparam int D_W          = COORD_W + 1;
  localparam int G_W          = TRIG_W + D_W + 1;
  localparam int E_W          = 2 * TRIG_W + 1;
  localparam int U_W          = SIZE_W + E_W;
  localparam int R_W          = U_W + 2;
  localparam int SEP_W        = R_W + 1;
  localparam int CENTER_SHIFT = TRIG_FRAC_BITS + 1;

  // stream widths
  localparam int IN_W  = 224;
  localparam int OUT_W = 8;

  // sine series
  localparam longint HALF_PI_Q30  = 1686629713;
  localparam int     TAYLOR_TERMS = 9;

  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_1,
    QUAD_2,
    QUAD_3
  } oro_quad_t;

  typedef enum logic [3:0] {
    G_X,
    G_X2,
    G_TM,
    G_QH,
    G_QS,
    G_QR,
    G_QC,
    G_WR,
    G_DONE
  } oro_gen_state_t;

  // sine table write port
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [SIN_W-1:0]  data;
  } oro_wr_t;

  // per-stage load enables for the lanes
  typedef struct packed {
    logic s3;
    logic s4;
    logic s5;
    logic s6;
  } oro_adv_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] s;
    logic signed [TRIG_W-1:0] c;
  } oro_trig_t;

  // divisor (2n)(2n+1) of series term n
  function automatic logic [8:0] taylor_div(input logic [3:0] n);
    logic [8:0] d;
    case (n)
      4'd2:    d = 9'd20;
      4'd3:    d = 9'd42;
      4'd4:    d = 9'd72;
      4'd5:    d = 9'd110;
      4'd6:    d = 9'd156;
      4'd7:    d = 9'd210;
      4'd8:    d = 9'd272;
      4'd9:    d = 9'd342;
      default: d = 9'd6;
    endcase
    return d;
  endfunction

  // floor(2^32 / divisor), never above the true reciprocal
  function automatic logic [29:0] taylor_recip(input logic [3:0] n);
    logic [29:0] m;
    case (n)
      4'd2:    m = 30'd214748364;
      4'd3:    m = 30'd102261126;
      4'd4:    m = 30'd59652323;
      4'd5:    m = 30'd39045157;
      4'd6:    m = 30'd27531841;
      4'd7:    m = 30'd20452225;
      4'd8:    m = 30'd15790320;
      4'd9:    m = 30'd12558383;
      default: m = 30'd715827882;
    endcase
    return m;
  endfunction

  // quadrant fold of the quarter-wave lookups
  function automatic oro_trig_t trig_sel(input oro_quad_t q, input logic [SIN_W-1:0] lo,
                                         input logic [SIN_W-1:0] hi);
    oro_trig_t t;
    logic signed [TRIG_W-1:0] lo_s;
    logic signed [TRIG_W-1:0] hi_s;
    lo_s = $signed(TRIG_W'(lo));
    hi_s = $signed(TRIG_W'(hi));
    unique case (q)
      QUAD_0: begin
        t.s = lo_s;
        t.c = hi_s;
      end
      QUAD_1: begin
        t.s = hi_s;
        t.c = -lo_s;
      end
      QUAD_2: begin
        t.s = -lo_s;
        t.c = -hi_s;
      end
      QUAD_3: begin
        t.s = -hi_s;
        t.c = lo_s;
      end
      default: begin
        t.s = lo_s;
        t.c = hi_s;
      end
    endcase
    return t;
  endfunction

endpackage

@@ rtl/oro_sine_gen.sv @@
// oro_sine_gen: fills the quarter-wave sine table after reset with a
// fixed-point series, entry by entry; depends on oro_pkg
`timescale 1ns / 1ps

module oro_sine_gen (
  input  logic            clk,
  input  logic            rst,
  output oro_pkg::oro_wr_t wr,
  output logic            done
);
  import oro_pkg::*;

  localparam int KX_W = ADDR_W + 31;

  oro_gen_state_t state, state_next;

  logic [ADDR_W-1:0] k;
  logic [3:0]        n;
  logic [30:0]       x;
  logic [31:0]       x2;
  logic [30:0]       term;
  logic signed [33:0] sum;
  logic [32:0]       p;
  logic [45:0]       ph_prod;
  logic [46:0]       pl_prod;
  logic [30:0]       q0;
  logic [11:0]       rem;

  logic [KX_W-1:0] kx_prod;
  logic [61:0]     xx_prod;
  logic [62:0]     tm_prod;
  logic [63:0]     q_sum;
  logic [39:0]     qd_prod;
  logic [8:0]      d;
  logic [29:0]     recip;
  logic [30:0]     q_fix;
  logic [11:0]     r_fix;
  logic [32:0]     sum_pos;
  logic [63:0]     rnd_full;
  logic [33:0]     rnd;
  logic [SIN_W-1:0] wr_data;
  logic            last_term;
  logic            last_k;

  assign d         = taylor_div(n);
  assign recip     = taylor_recip(n);
  assign last_term = (n == 4'(TAYLOR_TERMS));
  assign last_k    = (k == ADDR_W'(QUARTER));

  // arithmetic of the current step
  assign kx_prod = KX_W'(k) * KX_W'(HALF_PI_Q30);
  assign xx_prod = 62'(x) * 62'(x);
  assign tm_prod = 63'(term) * 63'(x2);
  assign q_sum   = (64'(ph_prod) << 17) + 64'(pl_prod);
  assign qd_prod = 40'(q0) * 40'(d);

  // reciprocal estimate is at most a few short, fix it up
  always_comb begin
    q_fix = q0;
    r_fix = rem;
    for (int i = 0; i < 4; i++) begin
      if (r_fix >= 12'(d)) begin
        r_fix = r_fix - 12'(d);
        q_fix = q_fix + 31'd1;
      end
    end
  end

  // round to trig format, clamp negatives to zero and the top to one
  always_comb begin
    sum_pos  = sum[33] ? '0 : sum[32:0];
    rnd_full = (64'(sum_pos) << TRIG_FRAC_BITS) + (64'd1 << 29);
    rnd      = 34'(rnd_full >> 30);
    if (rnd > (34'd1 << TRIG_FRAC_BITS)) begin
      wr_data = SIN_W'(34'd1 << TRIG_FRAC_BITS);
    end else begin
      wr_data = SIN_W'(rnd);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      G_X:    state_next = G_X2;
      G_X2:   state_next = G_TM;
      G_TM:   state_next = G_QH;
      G_QH:   state_next = G_QS;
      G_QS:   state_next = G_QR;
      G_QR:   state_next = G_QC;
      G_QC:   state_next = last_term ? G_WR : G_TM;
      G_WR:   state_next = last_k ? G_DONE : G_X;
      G_DONE: state_next = G_DONE;
      default: state_next = G_X;
    endcase
  end

  // outputs
  always_comb begin
    wr.en   = (state == G_WR);
    wr.addr = k;
    wr.data = wr_data;
    done    = (state == G_DONE);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= G_X;
      k     <= '0;
      n     <= 4'd1;
    end else begin
      state <= state_next;
      if (state == G_X2) begin
        n <= 4'd1;
      end else if (state == G_QC && !last_term) begin
        n <= n + 4'd1;
      end
      if (state == G_WR && !last_k) begin
        k <= k + ADDR_W'(1);
      end
    end
  end

  // series datapath
  always_ff @(posedge clk) begin
    unique case (state)
      G_X:  x <= 31'(kx_prod >> (ANGLE_BITS - 2));
      G_X2: begin
        x2   <= 32'(xx_prod >> 30);
        term <= x;
        sum  <= $signed({3'b000, x});
      end
      G_TM: p <= 33'(tm_prod >> 30);
      G_QH: begin
        ph_prod <= 46'(p[32:17]) * 46'(recip);
        pl_prod <= 47'(p[16:0]) * 47'(recip);
      end
      G_QS: q0  <= q_sum[62:32];
      G_QR: rem <= 12'(40'(p) - qd_prod);
      G_QC: begin
        term <= q_fix;
        if (n[0]) begin
          sum <= sum - $signed({3'b000, q_fix});
        end else begin
          sum <= sum + $signed({3'b000, q_fix});
        end
      end
      default: ;
    endcase
  end

  a_done_sticks: assert property (@(posedge clk) disable iff (rst) done |=> done)
    else $error("sine table fill restarted after completion");
  a_zero_entry: assert property (@(posedge clk) disable iff (rst)
    (wr.en && k == '0) |-> (wr.data == '0))
    else $error("sine of zero angle not zero");
  a_full_series: assert property (@(posedge clk) disable iff (rst) wr.en |-> last_term)
    else $error("table entry written before all series terms");

endmodule

@@ rtl/oro_sine_ram.sv @@
// oro_sine_ram: quarter-wave sine table memory, one write port and two
// registered read ports; depends on oro_pkg
`timescale 1ns / 1ps

module oro_sine_ram (
  input  logic                      clk,
  input  oro_pkg::oro_wr_t          wr,
  input  logic                      rd_en,
  input  logic [oro_pkg::ADDR_W-1:0] addr_lo,
  input  logic [oro_pkg::ADDR_W-1:0] addr_hi,
  output logic [oro_pkg::SIN_W-1:0]  data_lo,
  output logic [oro_pkg::SIN_W-1:0]  data_hi
);
  import oro_pkg::*;

  logic [SIN_W-1:0] mem [0:QUARTER];

  // fill port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // sine and cosine side lookups
  always_ff @(posedge clk) begin
    if (rd_en) begin
      data_lo <= mem[addr_lo];
      data_hi <= mem[addr_hi];
    end
  end

endmodule

@@ rtl/oro_lane.sv @@
// oro_lane: one candidate axis; projects both rectangles and flags a
// strict gap, four pipeline stages; depends on oro_pkg
`timescale 1ns / 1ps

module oro_lane (
  input  logic                              clk,
  input  oro_pkg::oro_adv_t                 adv,
  input  logic signed [oro_pkg::TRIG_W-1:0] ax,
  input  logic signed [oro_pkg::TRIG_W-1:0] ay,
  input  logic signed [oro_pkg::TRIG_W-1:0] ca,
  input  logic signed [oro_pkg::TRIG_W-1:0] sa,
  input  logic signed [oro_pkg::TRIG_W-1:0] cb,
  input  logic signed [oro_pkg::TRIG_W-1:0] sb,
  input  logic signed [oro_pkg::D_W-1:0]    dx,
  input  logic signed [oro_pkg::D_W-1:0]    dy,
  input  logic [oro_pkg::SIZE_W-1:0]        wa,
  input  logic [oro_pkg::SIZE_W-1:0]        ha,
  input  logic [oro_pkg::SIZE_W-1:0]        wb,
  input  logic [oro_pkg::SIZE_W-1:0]        hb,
  input  logic                              use_axis,
  output logic                              sep
);
  import oro_pkg::*;

  localparam int P_W  = 2 * TRIG_W;
  localparam int GP_W = TRIG_W + D_W;

  logic signed [P_W-1:0]  p_ac, p_as, p_bc, p_bs, p_ya, p_xa, p_yb, p_xb;
  logic signed [GP_W-1:0] p_gx, p_gy;

  logic signed [E_W-1:0] ea, fa, eb, fb;
  logic signed [G_W-1:0] g;
  logic [SIZE_W-1:0]     wa3, ha3, wb3, hb3;
  logic                  use3;

  logic [E_W-1:0]   ea_abs, fa_abs, eb_abs, fb_abs;
  logic [G_W-1:0]   g_abs;
  logic [U_W-1:0]   ua, va, ub, vb;
  logic [G_W-1:0]   gabs4;
  logic             use4;

  logic [U_W:0]     r1, r2;
  logic [G_W-1:0]   gabs5;
  logic             use5;

  logic [SEP_W-1:0] gap;
  logic [SEP_W-1:0] reach;

  // axis against each edge direction and against the center offset
  assign p_ac = ax * ca;
  assign p_as = ay * sa;
  assign p_ya = ay * ca;
  assign p_xa = ax * sa;
  assign p_bc = ax * cb;
  assign p_bs = ay * sb;
  assign p_yb = ay * cb;
  assign p_xb = ax * sb;
  assign p_gx = ax * dx;
  assign p_gy = ay * dy;

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      ea   <= E_W'(p_ac) + E_W'(p_as);
      fa   <= E_W'(p_ya) - E_W'(p_xa);
      eb   <= E_W'(p_bc) + E_W'(p_bs);
      fb   <= E_W'(p_yb) - E_W'(p_xb);
      g    <= G_W'(p_gx) + G_W'(p_gy);
      wa3  <= wa;
      ha3  <= ha;
      wb3  <= wb;
      hb3  <= hb;
      use3 <= use_axis;
    end
  end

  // magnitudes of the projected half extents
  assign ea_abs = ea[E_W-1] ? E_W'(-ea) : E_W'(ea);
  assign fa_abs = fa[E_W-1] ? E_W'(-fa) : E_W'(fa);
  assign eb_abs = eb[E_W-1] ? E_W'(-eb) : E_W'(eb);
  assign fb_abs = fb[E_W-1] ? E_W'(-fb) : E_W'(fb);
  assign g_abs  = g[G_W-1] ? G_W'(-g) : G_W'(g);

  always_ff @(posedge clk) begin
    if (adv.s4) begin
      ua    <= U_W'(wa3) * U_W'(ea_abs);
      va    <= U_W'(ha3) * U_W'(fa_abs);
      ub    <= U_W'(wb3) * U_W'(eb_abs);
      vb    <= U_W'(hb3) * U_W'(fb_abs);
      gabs4 <= g_abs;
      use4  <= use3;
    end
  end

  // partial radius sums
  always_ff @(posedge clk) begin
    if (adv.s5) begin
      r1    <= (U_W + 1)'(ua) + (U_W + 1)'(va);
      r2    <= (U_W + 1)'(ub) + (U_W + 1)'(vb);
      gabs5 <= gabs4;
      use5  <= use4;
    end
  end

  // strict gap: center distance beyond the two radii
  assign gap   = SEP_W'(gabs5) << CENTER_SHIFT;
  assign reach = SEP_W'(r1) + SEP_W'(r2);

  always_ff @(posedge clk) begin
    if (adv.s6) begin
      sep <= use5 && (gap > reach);
    end
  end

endmodule

@@ rtl/oriented_rect_overlap_test.sv @@
// oriented_rect_overlap_test: top level; sine table fill, trig lookup,
// four axis lanes and the merge; depends on oro_pkg, oro_sine_gen,
// oro_sine_ram, oro_lane
`timescale 1ns / 1ps

// Usage
//   Input stream s_*: one transfer carries a pair of rotated rectangles
//   (center, full size, binary angle each). Output stream m_*: one transfer
//   per input, bit 0 of m_tdata is 1 when no axis separates them, touching
//   included.
//   After reset the sine table is filled; s_tready stays low meanwhile.
//   Then one pair is accepted every cycle while the receiver does not stall;
//   the rate is set by the pipeline: the two table read ports per rectangle
//   and the four axis lanes each take one pair a cycle.
//   When the receiver stalls, the pipeline keeps accepting until its seven
//   stages are full, filling bubbles first; then s_tready drops until
//   m_tready returns. Results leave in input order.
module oriented_rect_overlap_test (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // a_center_x[23:0], a_center_y[47:24], a_width[70:48], a_height[93:71],
  // a_angle[109:94], b_center_x[133:110], b_center_y[157:134],
  // b_width[180:158], b_height[203:181], b_angle[219:204], zeros above
  input  logic [oro_pkg::IN_W-1:0]  s_tdata,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // overlapping[0], zeros above
  output logic [oro_pkg::OUT_W-1:0] m_tdata
);
  import oro_pkg::*;

  localparam int LANES = 4;

  oro_wr_t wr;
  logic    init_done;

  logic [7:1] v;
  logic [8:1] ld;
  oro_adv_t   adv;

  logic [ANGLE_BITS-3:0] a_res, b_res;
  logic [ADDR_W-1:0]     a_lo_addr, a_hi_addr, b_lo_addr, b_hi_addr;
  logic [SIN_W-1:0]      a_lo, a_hi, b_lo, b_hi;

  // stage 1
  logic signed [COORD_W-1:0] acx1, acy1, bcx1, bcy1;
  logic [SIZE_W-1:0]         aw1, ah1, bw1, bh1;
  oro_quad_t                 aq1, bq1;

  // stage 2
  oro_trig_t                 ta, tb;
  logic signed [TRIG_W-1:0]  ca2, sa2, cb2, sb2;
  logic signed [D_W-1:0]     dx2, dy2;
  logic [SIZE_W-1:0]         aw2, ah2, bw2, bh2;

  logic signed [TRIG_W-1:0] lane_ax [LANES];
  logic signed [TRIG_W-1:0] lane_ay [LANES];
  logic [LANES-1:0]         lane_use;
  logic [LANES-1:0]         lane_sep;

  logic overlapping;

  // sine table fill
  oro_sine_gen u_gen (
    .clk  (clk),
    .rst  (rst),
    .wr   (wr),
    .done (init_done)
  );

  // pipeline loads: a stage takes new data when empty or when it moves on
  always_comb begin
    ld[8] = m_tready;
    for (int i = 7; i >= 1; i--) begin
      ld[i] = !v[i] || ld[i+1];
    end
  end

  assign s_tready = ld[1] && init_done;
  assign adv      = '{s3: ld[3], s4: ld[4], s5: ld[5], s6: ld[6]};

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (ld[1]) begin
        v[1] <= s_tvalid && s_tready;
      end
      for (int i = 2; i <= 7; i++) begin
        if (ld[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // table addresses for both angles
  assign a_res     = s_tdata[94 +: ANGLE_BITS - 2];
  assign b_res     = s_tdata[204 +: ANGLE_BITS - 2];
  assign a_lo_addr = ADDR_W'(a_res);
  assign a_hi_addr = ADDR_W'(QUARTER) - ADDR_W'(a_res);
  assign b_lo_addr = ADDR_W'(b_res);
  assign b_hi_addr = ADDR_W'(QUARTER) - ADDR_W'(b_res);

  oro_sine_ram u_ram_a (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (ld[1]),
    .addr_lo (a_lo_addr),
    .addr_hi (a_hi_addr),
    .data_lo (a_lo),
    .data_hi (a_hi)
  );

  oro_sine_ram u_ram_b (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (ld[1]),
    .addr_lo (b_lo_addr),
    .addr_hi (b_hi_addr),
    .data_lo (b_lo),
    .data_hi (b_hi)
  );

  // stage 1: capture the transfer
  always_ff @(posedge clk) begin
    if (ld[1]) begin
      acx1 <= $signed(s_tdata[23:0]);
      acy1 <= $signed(s_tdata[47:24]);
      aw1  <= s_tdata[70:48];
      ah1  <= s_tdata[93:71];
      aq1  <= oro_quad_t'(s_tdata[94 + ANGLE_BITS - 2 +: 2]);
      bcx1 <= $signed(s_tdata[133:110]);
      bcy1 <= $signed(s_tdata[157:134]);
      bw1  <= s_tdata[180:158];
      bh1  <= s_tdata[203:181];
      bq1  <= oro_quad_t'(s_tdata[204 + ANGLE_BITS - 2 +: 2]);
    end
  end

  // stage 2: fold quadrants, center offset
  assign ta = trig_sel(aq1, a_lo, a_hi);
  assign tb = trig_sel(bq1, b_lo, b_hi);

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      ca2 <= ta.c;
      sa2 <= ta.s;
      cb2 <= tb.c;
      sb2 <= tb.s;
      dx2 <= D_W'(bcx1) - D_W'(acx1);
      dy2 <= D_W'(bcy1) - D_W'(acy1);
      aw2 <= aw1;
      ah2 <= ah1;
      bw2 <= bw1;
      bh2 <= bh1;
    end
  end

  // axes: normals of A then of B; a zero-length edge gives no axis
  assign lane_ax[0] = ca2;
  assign lane_ay[0] = sa2;
  assign lane_ax[1] = -sa2;
  assign lane_ay[1] = ca2;
  assign lane_ax[2] = cb2;
  assign lane_ay[2] = sb2;
  assign lane_ax[3] = -sb2;
  assign lane_ay[3] = cb2;
  assign lane_use   = {bw2 != '0, bh2 != '0, aw2 != '0, ah2 != '0};

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    oro_lane u_lane (
      .clk      (clk),
      .adv      (adv),
      .ax       (lane_ax[l]),
      .ay       (lane_ay[l]),
      .ca       (ca2),
      .sa       (sa2),
      .cb       (cb2),
      .sb       (sb2),
      .dx       (dx2),
      .dy       (dy2),
      .wa       (aw2),
      .ha       (ah2),
      .wb       (bw2),
      .hb       (bh2),
      .use_axis (lane_use[l]),
      .sep      (lane_sep[l])
    );
  end

  // merge: any separating axis clears the overlap
  always_ff @(posedge clk) begin
    if (ld[7]) begin
      overlapping <= !(|lane_sep);
    end
  end

  assign m_tvalid = v[7];
  assign m_tdata  = OUT_W'(overlapping);

  a_ready_after_fill: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> init_done)
    else $error("input taken before sine table filled");
  a_quiet_during_fill: assert property (@(posedge clk) disable iff (rst)
    !init_done |-> !m_tvalid)
    else $error("result offered before sine table filled");
  a_transfer_enters: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> v[1])
    else $error("accepted transfer lost at pipeline entry");

endmodule

@@ tb/oriented_rect_overlap_test_test.sv @@
// oriented_rect_overlap_test_test: self-checking testbench for the oriented
// rectangle overlap test; directed table then random pairs, with random
// idling on both stream sides; depends on oro_pkg and the rtl top level
`timescale 1ns / 1ps

module oriented_rect_overlap_test_test;

  import oro_pkg::*;

  localparam int  CYCLE_LIMIT = 3000000;
  localparam int  RANDOM_PAIRS = 1200;
  localparam int  DRAIN_CYCLES = 20;
  localparam int  USE_PREDICTOR = -1;
  localparam longint unsigned HALF_PI_Q2_30 = 64'd1686629713;

  typedef struct {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic [SIZE_W-1:0]         w;
    logic [SIZE_W-1:0]         h;
    logic [ANGLE_BITS-1:0]     ang;
  } rect_in_t;

  typedef struct {
    rect_in_t a;
    rect_in_t b;
    int       want;
  } pair_row_t;

  // corners kept doubled and scaled by the trig fraction
  typedef struct {
    longint x[4];
    longint y[4];
    longint s;
    longint c;
    bit     w_zero;
    bit     h_zero;
  } rect_geom_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [IN_W-1:0]      s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [OUT_W-1:0]     m_tdata;

  longint    sine_tab[QUARTER+1];
  bit        overlap_q[$];
  pair_row_t dir_rows[$];
  int        mismatches = 0;
  int        cycles = 0;
  bit        calm = 1'b0;
  int        stall_left = 0;

  oriented_rect_overlap_test dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // quarter-wave sine table, series in Q2.30 rounded to the trig format
  function automatic void fill_sine_tab();
    longint unsigned x, x2, term, r;
    longint sum;
    for (int k = 0; k <= QUARTER; k++) begin
      x = (longint'(k) * HALF_PI_Q2_30) / QUARTER;
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (int n = 1; n <= 9; n++) begin
        term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) sum -= longint'(term);
        else sum += longint'(term);
      end
      if (sum < 0) sum = 0;
      r = (longint'(sum) * (64'd1 << TRIG_FRAC_BITS) + (64'd1 << 29)) >> 30;
      if (r > (64'd1 << TRIG_FRAC_BITS)) r = 64'd1 << TRIG_FRAC_BITS;
      sine_tab[k] = longint'(r);
    end
  endfunction

  function automatic rect_geom_t corners_of(rect_in_t r);
    rect_geom_t g;
    int sgx[4] = '{1, 1, -1, -1};
    int sgy[4] = '{1, -1, -1, 1};
    logic [1:0] quad;
    int rem;
    longint lo, hi, cx, cy, wc, ws, hc, hs;
    quad = r.ang[ANGLE_BITS-1 -: 2];
    rem = r.ang & (QUARTER - 1);
    lo = sine_tab[rem];
    hi = sine_tab[QUARTER - rem];
    case (quad)
      2'd0: begin g.s = lo; g.c = hi; end
      2'd1: begin g.s = hi; g.c = -lo; end
      2'd2: begin g.s = -lo; g.c = -hi; end
      default: begin g.s = -hi; g.c = lo; end
    endcase
    cx = longint'(r.cx) * (64'sd1 << (TRIG_FRAC_BITS + 1));
    cy = longint'(r.cy) * (64'sd1 << (TRIG_FRAC_BITS + 1));
    wc = longint'(r.w) * g.c;
    ws = longint'(r.w) * g.s;
    hc = longint'(r.h) * g.c;
    hs = longint'(r.h) * g.s;
    for (int i = 0; i < 4; i++) begin
      g.x[i] = cx + sgx[i] * wc - sgy[i] * hs;
      g.y[i] = cy + sgx[i] * ws + sgy[i] * hc;
    end
    g.w_zero = (r.w == 0);
    g.h_zero = (r.h == 0);
    return g;
  endfunction

  // strict gap between the two spans on direction (ax, ay)
  function automatic bit axis_gap(rect_geom_t ga, rect_geom_t gb, longint ax, longint ay);
    longint mna, mxa, mnb, mxb, p;
    mna = ax * ga.x[0] + ay * ga.y[0];
    mxa = mna;
    mnb = ax * gb.x[0] + ay * gb.y[0];
    mxb = mnb;
    for (int i = 1; i < 4; i++) begin
      p = ax * ga.x[i] + ay * ga.y[i];
      if (p < mna) mna = p;
      if (p > mxa) mxa = p;
      p = ax * gb.x[i] + ay * gb.y[i];
      if (p < mnb) mnb = p;
      if (p > mxb) mxb = p;
    end
    return (mxa < mnb) || (mxb < mna);
  endfunction

  function automatic bit overlap_of(rect_in_t a, rect_in_t b);
    rect_geom_t ga, gb, g;
    ga = corners_of(a);
    gb = corners_of(b);
    for (int i = 0; i < 2; i++) begin
      g = (i == 0) ? ga : gb;
      // a zero-length edge gives a zero normal, which never separates
      if (!g.h_zero && axis_gap(ga, gb, g.c, g.s)) return 1'b0;
      if (!g.w_zero && axis_gap(ga, gb, -g.s, g.c)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic rect_in_t mk_rect(int cx, int cy, int w, int h, int ang);
    rect_in_t r;
    r.cx = cx[COORD_W-1:0];
    r.cy = cy[COORD_W-1:0];
    r.w = w[SIZE_W-1:0];
    r.h = h[SIZE_W-1:0];
    r.ang = ang[ANGLE_BITS-1:0];
    return r;
  endfunction

  task automatic add_row(rect_in_t a, rect_in_t b, int want);
    pair_row_t row;
    row.a = a;
    row.b = b;
    row.want = want;
    dir_rows = {dir_rows, row};
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic int rand_size();
    case ($urandom_range(0, 11))
      0: return 0;
      1: return 23'h7FFFFF;
      2: return $urandom_range(0, 8388607);
      default: return $urandom & ((1 << $urandom_range(1, 16)) - 1);
    endcase
  endfunction

  function automatic rect_in_t rand_rect();
    return mk_rect($urandom, $urandom, rand_size(), rand_size(), $urandom);
  endfunction

  // pair placed close enough that the answer goes either way
  function automatic void near_pair(output rect_in_t a, output rect_in_t b);
    int reach;
    a = rand_rect();
    a.cx = COORD_W'($urandom_range(0, 2097152) - 1048576);
    a.cy = COORD_W'($urandom_range(0, 2097152) - 1048576);
    b = rand_rect();
    if ($urandom_range(0, 7) == 0) b.ang = a.ang;
    reach = (int'(a.w) + int'(a.h) + int'(b.w) + int'(b.h)) / 2 + 2;
    if (reach > 4000000) reach = 4000000;
    b.cx = COORD_W'(int'(a.cx) + $urandom_range(0, 2 * reach) - reach);
    b.cy = COORD_W'(int'(a.cy) + $urandom_range(0, 2 * reach) - reach);
  endfunction

  // one input transfer, waiting out the handshake
  task automatic send_pair(rect_in_t a, rect_in_t b, int want);
    int gap;
    bit want_bit;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {4'b0, b.ang, b.h, b.w, b.cy, b.cx, a.ang, a.h, a.w, a.cy, a.cx};
    do @(posedge clk); while (!s_tready);
    want_bit = (want == USE_PREDICTOR) ? overlap_of(a, b) : want[0];
    overlap_q = {overlap_q, want_bit};
  endtask

  task automatic report_mismatch(string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    mismatches++;
  endtask

  // cycle limit, covers the table fill after reset
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("oriented_rect_overlap_test regression: fail");
      $finish;
    end
  end

  // stretches with no idling on either side
  always @(posedge clk) begin
    if ($urandom_range(0, 399) == 0) calm <= ~calm;
  end

  // receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // result check against the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (overlap_q.size() == 0) begin
        report_mismatch("result transfer with nothing expected");
      end else if (m_tdata[0] !== overlap_q[0]) begin
        report_mismatch($sformatf("overlapping got %b want %b", m_tdata[0], overlap_q[0]));
        void'(overlap_q.pop_front());
      end else begin
        void'(overlap_q.pop_front());
      end
    end
  end

  initial begin
    rect_in_t a, b;
    fill_sine_tab();

    // directed table
    add_row(mk_rect(0, 0, 512, 512, 0), mk_rect(0, 0, 512, 512, 0), 1);
    add_row(mk_rect(0, 0, 256, 256, 0), mk_rect(100000, 0, 256, 256, 0), 0);
    // touching edges count as overlap, one lsb apart does not
    add_row(mk_rect(0, 0, 512, 512, 0), mk_rect(512, 0, 512, 512, 0), 1);
    add_row(mk_rect(0, 0, 512, 512, 0), mk_rect(513, 0, 512, 512, 0), 0);
    add_row(mk_rect(0, 0, 512, 512, 0), mk_rect(0, -512, 512, 512, 0), 1);
    // two points: every axis is degenerate, nothing separates
    add_row(mk_rect(8388607, 8388607, 0, 0, 65535), mk_rect(-8388608, -8388608, 0, 0, 0), 1);
    add_row(mk_rect(8388607, 8388607, 8388607, 8388607, 65535),
            mk_rect(-8388608, -8388608, 8388607, 8388607, 0), USE_PREDICTOR);
    add_row(mk_rect(-8388608, 8388607, 8388607, 1, 32768),
            mk_rect(8388607, -8388608, 1, 8388607, 16384), USE_PREDICTOR);
    add_row(mk_rect(0, 0, 512, 512, 8192), mk_rect(700, 0, 512, 512, 0), USE_PREDICTOR);
    add_row(mk_rect(0, 0, 512, 512, 8192), mk_rect(620, 0, 512, 512, 0), USE_PREDICTOR);
    add_row(mk_rect(0, 0, 2048, 256, 16384), mk_rect(0, 900, 256, 256, 0), USE_PREDICTOR);
    add_row(mk_rect(0, 0, 2048, 256, 32768), mk_rect(900, 0, 256, 256, 49152), USE_PREDICTOR);
    add_row(mk_rect(0, 0, 2048, 256, 49152), mk_rect(0, -1100, 256, 256, 65535), USE_PREDICTOR);
    add_row(mk_rect(0, 0, 2048, 256, 65535), mk_rect(1100, 10, 256, 256, 24576), USE_PREDICTOR);
    // zero width or height: lines
    add_row(mk_rect(0, 0, 0, 2048, 0), mk_rect(0, 0, 2048, 0, 16384), USE_PREDICTOR);
    add_row(mk_rect(0, 0, 0, 2048, 4096), mk_rect(600, 0, 2048, 0, 40000), USE_PREDICTOR);
    add_row(mk_rect(0, 0, 0, 2048, 0), mk_rect(1, 0, 0, 2048, 0), USE_PREDICTOR);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_pair(dir_rows[i].a, dir_rows[i].b, dir_rows[i].want);

    // random pairs, mostly near each other
    for (int n = 0; n < RANDOM_PAIRS; n++) begin
      if ($urandom_range(0, 4) == 0) begin
        a = rand_rect();
        b = rand_rect();
      end else begin
        near_pair(a, b);
      end
      send_pair(a, b, USE_PREDICTOR);
    end
    s_tvalid <= 1'b0;

    while (overlap_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("oriented_rect_overlap_test regression: pass");
    end else begin
      $display("oriented_rect_overlap_test regression: fail");
    end
    $finish;
  end

endmodule

@@ oriented_rect_overlap_test.f @@
rtl/oro_pkg.sv
rtl/oro_sine_gen.sv
rtl/oro_sine_ram.sv
rtl/oro_lane.sv
rtl/oriented_rect_overlap_test.sv
tb/oriented_rect_overlap_test_test.sv
